@@ hdl/first_best_fit_segment_allocator_top_defines.svh @@
// Assertion macros shared by the segment allocator RTL
`ifndef FIRST_BEST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_BEST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FBFSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FBFSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fbfsa_pkg.sv @@
// Package with shared types and constants of the segment allocator
`timescale 1ns / 1ps
package fbfsa_pkg;

    localparam int SIZE_W = 16;
    localparam int DATA_W = 16;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REQ_ADD   = 1'b0,
        REQ_ALLOC = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LAUNCH = 2'd1,
        S_SCAN   = 2'd2,
        S_DONE   = 2'd3
    } t_state;

endpackage

@@ hdl/fbfsa_cell.sv @@
// One slot cell of the allocator chain: holds a segment and refines the scan word
`timescale 1ns / 1ps
`include "first_best_fit_segment_allocator_top_defines.svh"
module fbfsa_cell
    import fbfsa_pkg::*;
#(
    parameter int  ADDR_BITS = 16,
    parameter int  IDX_W     = 3,
    parameter int  INDEX     = 0,
    parameter type t_scan    = logic,
    parameter type t_upd     = logic
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_policy,
    input  logic [SIZE_W-1:0] i_req_size,
    input  t_scan             i_scan,
    output t_scan             o_scan,
    input  t_upd              i_upd
);

    logic                 r_valid;
    logic [SIZE_W-1:0]    r_size;
    logic [ADDR_BITS-1:0] r_start;
    t_scan                r_scan;

    logic                 n_valid;
    logic [SIZE_W-1:0]    n_size;
    logic [ADDR_BITS-1:0] n_start;
    t_scan                n_scan;

    logic                 w_cand;
    logic                 w_better;
    logic                 w_hit;
    logic [SIZE_W-1:0]    w_rem;

    always_comb begin
        w_cand = r_valid && (r_size >= i_req_size);
        if (!i_scan.fit_hit) begin
            w_better = 1'b1;
        end else if (i_policy) begin
            w_better = (r_size < i_scan.fit_size) ||
                       ((r_size == i_scan.fit_size) && (r_start < i_scan.fit_start));
        end else begin
            w_better = r_start < i_scan.fit_start;
        end
        n_scan = i_scan;
        if (w_cand && w_better) begin
            n_scan.fit_hit   = 1'b1;
            n_scan.fit_idx   = IDX_W'(INDEX);
            n_scan.fit_size  = r_size;
            n_scan.fit_start = r_start;
        end
        if (!r_valid && !i_scan.free_hit) begin
            n_scan.free_hit = 1'b1;
            n_scan.free_idx = IDX_W'(INDEX);
        end
    end

    always_comb begin
        w_hit   = i_upd.en && (i_upd.idx == IDX_W'(INDEX));
        w_rem   = r_size - i_upd.size;
        n_valid = r_valid;
        n_size  = r_size;
        n_start = r_start;
        if (w_hit) begin
            if (i_upd.add) begin
                n_valid = 1'b1;
                n_size  = i_upd.size;
                n_start = i_upd.start;
            end else begin
                n_size  = w_rem;
                n_start = r_start + ADDR_BITS'(i_upd.size);
                if (w_rem == '0) begin
                    n_valid = 1'b0;
                    n_start = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_scan  <= '0;
        end else begin
            r_valid <= n_valid;
            r_scan  <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_start <= n_start;
    end

    assign o_scan = r_scan;

    `FBFSA_ASSERT_NOW(a_live_nonzero, r_valid, r_size != '0, "live slot holds zero size")
    `FBFSA_ASSERT_NEXT(a_add_fills, w_hit && i_upd.add, r_valid, "add did not fill slot")
    `FBFSA_ASSERT_NOW(a_upd_idle_scan, i_upd.en, !i_scan.vld, "update during scan")

endmodule

@@ hdl/first_best_fit_segment_allocator_top.sv @@
// A request goes S_LAUNCH, slot chain scan, S_DONE; a zero size goes straight to S_DONE.
// New requests are taken only in S_IDLE, so a request cannot overlap the previous scan.
// A finished result waits in the output register while the next request is accepted.
// Reset: synchronous active low; table empty, fit policy first fit, no result pending.
`timescale 1ns / 1ps
`include "first_best_fit_segment_allocator_top_defines.svh"
module first_best_fit_segment_allocator_top
    import fbfsa_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int ADDR_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_fit_policy,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic              i_req_type,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic [DATA_W-1:0] i_seg_start,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic              o_ok,
    output logic [DATA_W-1:0] o_alloc_addr,
    output logic [1:0]        o_status
);

    localparam int IDX_W = $clog2(SLOTS);

    typedef struct packed {
        logic                 vld;
        logic                 fit_hit;
        logic [IDX_W-1:0]     fit_idx;
        logic [SIZE_W-1:0]    fit_size;
        logic [ADDR_BITS-1:0] fit_start;
        logic                 free_hit;
        logic [IDX_W-1:0]     free_idx;
    } t_scan;

    typedef struct packed {
        logic                 en;
        logic                 add;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_W-1:0]    size;
        logic [ADDR_BITS-1:0] start;
    } t_upd;

    t_state            r_state;
    t_state            n_state;
    logic              r_policy;
    t_req              r_type;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_BITS-1:0] r_start;
    logic              r_zero;
    t_scan             r_tail;
    logic              r_rsp_valid;
    logic              r_ok;
    logic [DATA_W-1:0] r_addr;
    t_status           r_status;

    t_req              n_type;
    logic [SIZE_W-1:0] n_size;
    logic [ADDR_BITS-1:0] n_start;
    logic              n_zero;
    t_scan             n_tail;
    logic              n_rsp_valid;
    logic              n_ok;
    logic [DATA_W-1:0] n_addr;
    t_status           n_status;

    t_scan             w_launch;
    t_scan             w_chain [SLOTS];
    t_upd              w_upd;
    logic              w_req_acc;
    logic              w_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
        end else if (i_cfg_valid) begin
            r_policy <= i_fit_policy;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            fbfsa_cell #(
                .ADDR_BITS (ADDR_BITS),
                .IDX_W     (IDX_W),
                .INDEX     (gi),
                .t_scan    (t_scan),
                .t_upd     (t_upd)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_policy   (r_policy),
                .i_req_size (r_size),
                .i_scan     ((gi == 0) ? w_launch : w_chain[(gi == 0) ? 0 : gi - 1]),
                .o_scan     (w_chain[gi]),
                .i_upd      (w_upd)
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_type      = r_type;
        n_size      = r_size;
        n_start     = r_start;
        n_zero      = r_zero;
        n_tail      = r_tail;
        n_ok        = r_ok;
        n_addr      = r_addr;
        n_status    = r_status;
        o_req_ready = 1'b0;
        w_load      = 1'b0;
        w_launch    = '0;
        w_upd       = '0;
        w_upd.size  = r_size;
        w_upd.start = r_start;
        w_req_acc   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                w_req_acc   = i_req_valid;
                if (i_req_valid) begin
                    n_type  = t_req'(i_req_type);
                    n_size  = i_req_size;
                    n_start = ADDR_BITS'(i_seg_start);
                    n_zero  = (i_req_size == '0);
                    n_state = (i_req_size == '0) ? S_DONE : S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                w_launch.vld = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                if (w_chain[SLOTS-1].vld) begin
                    n_tail  = w_chain[SLOTS-1];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    w_load  = 1'b1;
                    n_addr  = '0;
                    n_state = S_IDLE;
                    if (r_zero) begin
                        n_status = ST_ZERO;
                    end else if (r_type == REQ_ADD) begin
                        if (r_tail.free_hit) begin
                            n_status  = ST_DONE;
                            w_upd.en  = 1'b1;
                            w_upd.add = 1'b1;
                            w_upd.idx = r_tail.free_idx;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else begin
                        if (r_tail.fit_hit) begin
                            n_status  = ST_DONE;
                            n_addr    = DATA_W'(r_tail.fit_start);
                            w_upd.en  = 1'b1;
                            w_upd.idx = r_tail.fit_idx;
                        end else begin
                            n_status = ST_NOFIT;
                        end
                    end
                    n_ok = (n_status == ST_DONE);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_rsp_valid = w_load || (r_rsp_valid && !i_rsp_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_size   <= n_size;
        r_start  <= n_start;
        r_zero   <= n_zero;
        r_tail   <= n_tail;
        r_ok     <= n_ok;
        r_addr   <= n_addr;
        r_status <= n_status;
    end

    assign o_rsp_valid  = r_rsp_valid;
    assign o_ok         = r_ok;
    assign o_alloc_addr = r_addr;
    assign o_status     = r_status;

    `FBFSA_ASSERT_NOW(a_tail_in_scan, w_chain[SLOTS-1].vld, r_state == S_SCAN, "stray scan word")
    `FBFSA_ASSERT_NOW(a_ok_match, o_rsp_valid, o_ok == (o_status == ST_DONE), "ok/status mismatch")
    `FBFSA_ASSERT_NOW(a_fail_addr, o_rsp_valid && (o_status != ST_DONE), o_alloc_addr == '0, "failed request returns address")
    `FBFSA_ASSERT_NEXT(a_accept_next, w_req_acc, (r_state == S_LAUNCH) || (r_state == S_DONE), "bad state after accept")

endmodule
